FILE: rtl/qida_pkg.sv
// Shared types and codes for the queue id allocator.
// Depends on nothing; the core and its checker import it.
package qida_pkg;

    // Request codes carried by s_action.
    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_FREE     = 3'd1;
    localparam logic [2:0] ACT_SINC     = 3'd2;
    localparam logic [2:0] ACT_SDEC     = 3'd3;
    localparam logic [2:0] ACT_CINC     = 3'd4;
    localparam logic [2:0] ACT_CDEC     = 3'd5;

    // Result status codes.
    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_BAD_DEVICE = 3'd1;
    localparam logic [2:0] STS_BAD_ID     = 3'd2;
    localparam logic [2:0] STS_NONE_FREE  = 3'd3;
    localparam logic [2:0] STS_COUNT_ZERO = 3'd4;
    localparam logic [2:0] STS_COUNT_FULL = 3'd5;
    localparam logic [2:0] STS_LIST_FULL  = 3'd6;

    // Saturation value of both reference counts.
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Register index of the device number.
    localparam logic REG_DEVICE_NUMBER = 1'b0;

    // Sequencer states.
    typedef enum logic [3:0] {
        INIT = 4'b0001,
        IDLE = 4'b0010,
        POP  = 4'b0100,
        EXEC = 4'b1000
    } state_t;

endpackage

FILE: rtl/queue_id_allocator_with_refcounts_core.sv
// Queue id allocator core: free-id stack and per-id reference counts in memories.
// Depends on qida_pkg.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+----------------------------------------
//   s_       | in        | s_valid/s_ready  | action, device, queue_id
//   m_       | out       | m_valid/m_ready  | status, granted_id, stream/comm count
//   apb      | in        | psel/penable     | device_number at address 0
//
// The result register loads in EXEC. The count memory entry is read at acceptance, or,
// for an alloc that finds a free id, in POP once the stack memory has given the popped
// id; it is written back in EXEC. A new request is taken only in IDLE, once EXEC is done.
// After reset the block sweeps all QUEUE_COUNT entries of both memories with s_ready
// low; APB writes are taken meanwhile. A result waiting in the output register stalls
// only the final write-back step.
module queue_id_allocator_with_refcounts_core #(
    parameter int QUEUE_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [1:0]  s_device,
    input  logic [5:0]  s_queue_id,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [5:0]  m_granted_id,
    output logic [15:0] m_stream_count,
    output logic [15:0] m_comm_count,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qida_pkg::*;

    localparam int AW  = $clog2(QUEUE_COUNT);
    // One bit above both the id width and the request field so QUEUE_COUNT itself fits.
    localparam int WID = ((AW > 6) ? AW : 6) + 1;
    localparam int FCW = $clog2(QUEUE_COUNT + 1);

    // Configuration register.
    logic [1:0] dev_num_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEVICE_NUMBER);
    assign prdata = (paddr[2] == REG_DEVICE_NUMBER) ? {30'd0, dev_num_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_num_reg <= 2'd0;
        end else if (cfg_wr) begin
            dev_num_reg <= pwdata[1:0];
        end
    end

    // Memories: free-id stack and packed {stream, comm} counts.
    logic [AW-1:0] stk_mem [QUEUE_COUNT];
    logic [31:0]   cnt_mem [QUEUE_COUNT];

    logic          stk_we, stk_re, cnt_we, cnt_re;
    logic [AW-1:0] stk_waddr, stk_raddr, cnt_waddr, cnt_raddr;
    logic [AW-1:0] stk_wdata, stk_rdata_reg;
    logic [31:0]   cnt_wdata, cnt_rdata_reg;

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    // Sequencer and request context.
    state_t        state_reg, state_next;
    logic [AW-1:0] init_cnt_reg;
    logic [FCW-1:0] fc_reg, fc_next;
    logic [FCW-1:0] fc_m1;
    logic [2:0]    act_reg;
    logic          bad_dev_reg, undef_reg, have_id_reg, none_free_reg;
    logic [AW-1:0] id_reg;

    logic          accept, out_free, exec_fire;
    logic [WID-1:0] qid_ext;
    logic          s_have_id, s_bad_dev, s_undef, s_alloc, s_none_free;

    assign s_ready   = (state_reg == IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid || m_ready;
    assign exec_fire = (state_reg == EXEC) && out_free;
    assign fc_m1     = fc_reg - FCW'(1);

    assign qid_ext     = WID'(s_queue_id);
    assign s_have_id   = qid_ext < WID'(QUEUE_COUNT);
    assign s_bad_dev   = s_device != dev_num_reg;
    assign s_undef     = s_action > ACT_CDEC;
    assign s_alloc     = !s_bad_dev && !s_undef && (s_action == ACT_ALLOC);
    assign s_none_free = (fc_reg == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            INIT: begin
                if (init_cnt_reg == AW'(QUEUE_COUNT - 1)) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (accept) begin
                    state_next = (s_alloc && !s_none_free) ? POP : EXEC;
                end
            end
            POP: begin
                state_next = EXEC;
            end
            EXEC: begin
                if (out_free) begin
                    state_next = IDLE;
                end
            end
            default: state_next = INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= INIT;
            init_cnt_reg <= '0;
            fc_reg       <= FCW'(QUEUE_COUNT);
        end else begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            if (state_reg == INIT) begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
        end
    end

    // Request context captured at acceptance; an alloc replaces the id on the pop.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg       <= s_action;
            bad_dev_reg   <= s_bad_dev;
            undef_reg     <= s_undef;
            have_id_reg   <= s_have_id;
            none_free_reg <= s_none_free;
            id_reg        <= qid_ext[AW-1:0];
        end else if (state_reg == POP) begin
            id_reg      <= stk_rdata_reg;
            have_id_reg <= 1'b1;
        end
    end

    // Read ports: the stack top on an alloc, the count entry once the id is known.
    always_comb begin
        stk_re    = accept && s_alloc && !s_none_free;
        stk_raddr = fc_m1[AW-1:0];
        cnt_re    = 1'b0;
        cnt_raddr = qid_ext[AW-1:0];
        if (state_reg == POP) begin
            cnt_re    = 1'b1;
            cnt_raddr = stk_rdata_reg;
        end else if (accept && !s_alloc && s_have_id) begin
            cnt_re = 1'b1;
        end
    end

    // Execute step: decide status, new counts and stack update.
    logic [15:0] sc, cc, new_sc, new_cc;
    logic [2:0]  sts;
    logic        report, cnt_upd, push, pop_done;

    assign sc = cnt_rdata_reg[31:16];
    assign cc = cnt_rdata_reg[15:0];

    always_comb begin
        sts      = STS_OK;
        new_sc   = sc;
        new_cc   = cc;
        report   = have_id_reg;
        cnt_upd  = 1'b0;
        push     = 1'b0;
        pop_done = 1'b0;
        if (bad_dev_reg) begin
            sts = STS_BAD_DEVICE;
        end else if (undef_reg) begin
            sts = STS_OK;
        end else if (act_reg == ACT_ALLOC) begin
            if (none_free_reg) begin
                sts    = STS_NONE_FREE;
                report = 1'b0;
            end else begin
                pop_done = 1'b1;
            end
        end else if (!have_id_reg) begin
            sts = STS_BAD_ID;
        end else begin
            case (act_reg)
                ACT_FREE: begin
                    if (fc_reg >= FCW'(QUEUE_COUNT)) begin
                        sts = STS_LIST_FULL;
                    end else begin
                        push    = 1'b1;
                        new_sc  = 16'd0;
                        cnt_upd = 1'b1;
                    end
                end
                ACT_SINC: begin
                    if (sc == COUNT_MAX) begin
                        sts = STS_COUNT_FULL;
                    end else begin
                        new_sc  = sc + 16'd1;
                        cnt_upd = 1'b1;
                        if (sc == 16'd0) begin
                            new_cc = 16'd0;
                        end
                    end
                end
                ACT_SDEC: begin
                    if (sc == 16'd0) begin
                        sts = STS_COUNT_ZERO;
                    end else begin
                        new_sc  = sc - 16'd1;
                        cnt_upd = 1'b1;
                        if (sc == 16'd1) begin
                            new_cc = 16'd0;
                        end
                    end
                end
                ACT_CINC: begin
                    if (sc == 16'd0) begin
                        sts = STS_COUNT_ZERO;
                    end else if (cc == COUNT_MAX) begin
                        sts = STS_COUNT_FULL;
                    end else begin
                        new_cc  = cc + 16'd1;
                        cnt_upd = 1'b1;
                    end
                end
                default: begin
                    if (cc == 16'd0) begin
                        sts = STS_COUNT_ZERO;
                    end else begin
                        new_cc  = cc - 16'd1;
                        cnt_upd = 1'b1;
                    end
                end
            endcase
        end
    end

    // Write ports: the reset sweep, else the execute step.
    always_comb begin
        if (state_reg == INIT) begin
            stk_we    = 1'b1;
            stk_waddr = init_cnt_reg;
            stk_wdata = AW'(QUEUE_COUNT - 1) - init_cnt_reg;
            cnt_we    = 1'b1;
            cnt_waddr = init_cnt_reg;
            cnt_wdata = 32'd0;
        end else begin
            stk_we    = exec_fire && push;
            stk_waddr = fc_reg[AW-1:0];
            stk_wdata = id_reg;
            cnt_we    = exec_fire && cnt_upd;
            cnt_waddr = id_reg;
            cnt_wdata = {new_sc, new_cc};
        end
    end

    always_comb begin
        fc_next = fc_reg;
        if (exec_fire && push) begin
            fc_next = fc_reg + FCW'(1);
        end else if (exec_fire && pop_done) begin
            fc_next = fc_m1;
        end
    end

    // Output register.
    logic           m_valid_reg;
    logic [2:0]     m_status_reg;
    logic [5:0]     m_granted_reg;
    logic [15:0]    m_sc_reg, m_cc_reg;
    logic [WID-1:0] id_ext;

    assign id_ext = WID'(id_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_status_reg  <= sts;
            m_granted_reg <= pop_done ? id_ext[5:0] : 6'd0;
            m_sc_reg      <= report ? new_sc : 16'd0;
            m_cc_reg      <= report ? new_cc : 16'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_id   = m_granted_reg;
    assign m_stream_count = m_sc_reg;
    assign m_comm_count   = m_cc_reg;

endmodule

FILE: rtl/qida_checker.sv
// Port-level checker for the queue id allocator core, with its bind statement.
// Depends on qida_pkg and queue_id_allocator_with_refcounts_core.
module qida_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [5:0]  m_granted_id,
    input logic [15:0] m_stream_count,
    input logic [15:0] m_comm_count
);
    import qida_pkg::*;

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_id)
            && $stable(m_stream_count) && $stable(m_comm_count))
        else $error("result changed while stalled");

    // Only defined status codes are reported.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= STS_LIST_FULL)
        else $error("undefined status code");

    // A nonzero granted id only comes with a successful request.
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_granted_id != 6'd0) |-> m_status == STS_OK)
        else $error("granted id on a failed request");

    // Requests without an addressed id report zero counts.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STS_BAD_ID || m_status == STS_NONE_FREE)
            |-> m_stream_count == 16'd0 && m_comm_count == 16'd0)
        else $error("counts reported without an id");

endmodule

bind queue_id_allocator_with_refcounts_core qida_checker u_qida_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_granted_id   (m_granted_id),
    .m_stream_count (m_stream_count),
    .m_comm_count   (m_comm_count)
);

FILE: sim/queue_id_allocator_with_refcounts_core_tb.sv
// Self-checking testbench for queue_id_allocator_with_refcounts_core.
// Keeps its own model of the free stack and the reference counts and checks every result.
// Depends on qida_pkg and the core RTL.
`timescale 1ns / 1ps

module queue_id_allocator_with_refcounts_core_tb;
    import qida_pkg::*;

    localparam int QUEUE_COUNT = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 40;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int COUNT_RAMP = 48;
    localparam longint TIMEOUT_NS = 5_000_000;

    // Action codes the block must ignore.
    localparam logic [2:0] ACT_UNDEF_6 = 3'd6;
    localparam logic [2:0] ACT_UNDEF_7 = 3'd7;

    // Byte address of the device number register.
    localparam logic [2:0] DEVICE_NUMBER_ADDR = {REG_DEVICE_NUMBER, 2'b00};

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  granted_id;
        logic [15:0] stream_count;
        logic [15:0] comm_count;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = ACT_ALLOC;
    logic [1:0]  s_device = 2'd0;
    logic [5:0]  s_queue_id = 6'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [5:0]  m_granted_id;
    logic [15:0] m_stream_count;
    logic [15:0] m_comm_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Model state: free stack, its depth, both count tables and the device number.
    logic [5:0]  free_id_stack [QUEUE_COUNT];
    int unsigned free_depth;
    logic [15:0] stream_table [QUEUE_COUNT];
    logic [15:0] comm_table [QUEUE_COUNT];
    logic [1:0]  cfg_device;

    alloc_result_t pending_results[$];
    alloc_result_t last_prediction;

    int tx_idle_max = 16;
    int rx_idle_max = 16;
    int rx_hold_cycles = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int mismatches = 0;

    queue_id_allocator_with_refcounts_core #(
        .QUEUE_COUNT(QUEUE_COUNT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_device(s_device),
        .s_queue_id(s_queue_id),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_granted_id(m_granted_id),
        .m_stream_count(m_stream_count),
        .m_comm_count(m_comm_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Puts the model into its post-reset state.
    function automatic void reset_allocator_model();
        for (int i = 0; i < QUEUE_COUNT; i++) begin
            free_id_stack[i] = 6'(QUEUE_COUNT - 1 - i);
            stream_table[i] = 16'd0;
            comm_table[i] = 16'd0;
        end
        free_depth = QUEUE_COUNT;
        cfg_device = 2'd0;
    endfunction

    // Applies one request to the model and returns the result it should produce.
    function automatic alloc_result_t predict_allocator_step(
        logic [2:0] act, logic [1:0] dev, logic [5:0] qid
    );
        alloc_result_t r;
        int unsigned id;
        bit id_valid;
        r = '0;
        r.status = STS_OK;
        id = qid;
        id_valid = (qid < QUEUE_COUNT);
        if (dev != cfg_device || act > ACT_CDEC) begin
            r.status = (dev != cfg_device) ? STS_BAD_DEVICE : STS_OK;
        end else if (act == ACT_ALLOC) begin
            if (free_depth == 0) begin
                r.status = STS_NONE_FREE;
                id_valid = 1'b0;
            end else begin
                free_depth--;
                id = free_id_stack[free_depth];
                r.granted_id = id[5:0];
            end
        end else if (!id_valid) begin
            r.status = STS_BAD_ID;
        end else begin
            case (act)
                ACT_FREE: begin
                    if (free_depth >= QUEUE_COUNT) begin
                        r.status = STS_LIST_FULL;
                    end else begin
                        free_id_stack[free_depth] = 6'(id);
                        free_depth++;
                        stream_table[id] = 16'd0;
                    end
                end
                ACT_SINC: begin
                    if (stream_table[id] == COUNT_MAX) begin
                        r.status = STS_COUNT_FULL;
                    end else begin
                        stream_table[id]++;
                        if (stream_table[id] == 16'd1) comm_table[id] = 16'd0;
                    end
                end
                ACT_SDEC: begin
                    if (stream_table[id] == 16'd0) begin
                        r.status = STS_COUNT_ZERO;
                    end else begin
                        stream_table[id]--;
                        if (stream_table[id] == 16'd0) comm_table[id] = 16'd0;
                    end
                end
                ACT_CINC: begin
                    if (stream_table[id] == 16'd0) r.status = STS_COUNT_ZERO;
                    else if (comm_table[id] == COUNT_MAX) r.status = STS_COUNT_FULL;
                    else comm_table[id]++;
                end
                default: begin
                    if (comm_table[id] == 16'd0) r.status = STS_COUNT_ZERO;
                    else comm_table[id]--;
                end
            endcase
        end
        if (id_valid && r.status != STS_BAD_ID) begin
            r.stream_count = stream_table[id];
            r.comm_count = comm_table[id];
        end
        return r;
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        end
    endtask

    // Offers one request after a random gap and records its prediction once accepted.
    task automatic send_request(logic [2:0] act, logic [1:0] dev, logic [5:0] qid);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_device <= dev;
        s_queue_id <= qid;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        last_prediction = predict_allocator_step(act, dev, qid);
        pending_results.push_back(last_prediction);
        if (act <= ACT_CDEC) requests_sent++;
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the device number, then reads it back in a second transfer.
    task automatic write_device_number(logic [1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DEVICE_NUMBER_ADDR;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        cfg_device = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("device_number readback", value, prdata[1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random or held-off ready, one transaction per loop.
    initial begin
        int gap;
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Compares every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, m_status);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("status", want.status, m_status);
                check_field("granted_id", want.granted_id, m_granted_id);
                check_field("stream_count", want.stream_count, m_stream_count);
                check_field("comm_count", want.comm_count, m_comm_count);
            end
        end
    end

    task automatic test_config_after_reset();
        write_device_number(2'd0);
    endtask

    // Short walk through every action and several of their corner cases.
    task automatic test_directed_requests();
        send_request(ACT_ALLOC, 2'd0, 6'd0);
        send_request(ACT_ALLOC, 2'd0, 6'd63);
        send_request(ACT_SINC, 2'd0, 6'd0);
        send_request(ACT_CINC, 2'd0, 6'd0);
        send_request(ACT_CINC, 2'd0, 6'd0);
        send_request(ACT_CDEC, 2'd0, 6'd0);
        send_request(ACT_SINC, 2'd0, 6'd0);
        send_request(ACT_SDEC, 2'd0, 6'd0);
        // Stream count returning to zero clears the comm count.
        send_request(ACT_SDEC, 2'd0, 6'd0);
        send_request(ACT_SDEC, 2'd0, 6'd0);
        send_request(ACT_CDEC, 2'd0, 6'd0);
        send_request(ACT_CINC, 2'd0, 6'd0);
        send_request(ACT_SINC, 2'd0, 6'd63);
        send_request(ACT_CINC, 2'd0, 6'd63);
        // Id 63 is still on the stack, so this free pushes it a second time.
        send_request(ACT_FREE, 2'd0, 6'd63);
        send_request(ACT_SINC, 2'd0, 6'd63);
        send_request(ACT_ALLOC, 2'd3, 6'd63);
        send_request(ACT_CINC, 2'd2, 6'd63);
        send_request(ACT_UNDEF_6, 2'd0, 6'd63);
        send_request(ACT_UNDEF_7, 2'd1, 6'd42);
        send_request(ACT_FREE, 2'd0, 6'd0);
        send_request(ACT_FREE, 2'd0, 6'd1);
        send_request(ACT_ALLOC, 2'd0, 6'd21);
        send_request(ACT_FREE, 2'd0, 6'd0);
        wait_drained();
    endtask

    // Ramps both counts of one id up back to back, then steps each down once.
    task automatic test_count_ramp();
        tx_idle_max = 0;
        rx_idle_max = 0;
        repeat (COUNT_RAMP) send_request(ACT_SINC, cfg_device, 6'd42);
        repeat (COUNT_RAMP) send_request(ACT_CINC, cfg_device, 6'd42);
        send_request(ACT_CDEC, cfg_device, 6'd42);
        send_request(ACT_SDEC, cfg_device, 6'd42);
        wait_drained();
        tx_idle_max = 16;
        rx_idle_max = 16;
    endtask

    // Empties the free stack past the bottom, then refills it past the top.
    task automatic test_stack_empty_and_full();
        repeat (QUEUE_COUNT + 2) send_request(ACT_ALLOC, cfg_device, 6'($urandom));
        for (int i = 0; i < QUEUE_COUNT; i++) send_request(ACT_FREE, cfg_device, 6'(i));
        send_request(ACT_FREE, cfg_device, 6'($urandom));
        wait_drained();
    endtask

    // Allocates an id and runs a random sequence of count updates on it.
    task automatic run_id_lifecycle();
        logic [5:0] id;
        int steps;
        int pick;
        send_request(ACT_ALLOC, cfg_device, 6'($urandom));
        id = (last_prediction.status == STS_OK) ? last_prediction.granted_id : 6'($urandom);
        steps = $urandom_range(1, 10);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) send_request(ACT_SINC, cfg_device, id);
            else if (pick < 60) send_request(ACT_CINC, cfg_device, id);
            else if (pick < 75) send_request(ACT_CDEC, cfg_device, id);
            else if (pick < 95) send_request(ACT_SDEC, cfg_device, id);
            else send_request(ACT_SINC, cfg_device + 2'($urandom_range(1, 3)), id);
        end
        if ($urandom_range(0, 9) < 7) send_request(ACT_FREE, cfg_device, id);
    endtask

    task automatic send_random_noise();
        repeat ($urandom_range(1, 3)) begin
            send_request(3'($urandom), 2'($urandom), 6'($urandom));
        end
    endtask

    // Holds the result side off long enough to back the block up into its input.
    task automatic test_output_stall();
        tx_idle_max = 0;
        rx_idle_max = 0;
        rx_hold_cycles = 300;
        repeat (6) run_id_lifecycle();
        wait_drained();
        tx_idle_max = 16;
        rx_idle_max = 16;
    endtask

    // Random phases, each under its own device number and idling pattern.
    task automatic test_random_traffic();
        logic [1:0] phase_device [4];
        int phase_target;
        phase_device = '{2'd3, 2'd1, 2'd2, 2'd0};
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_device_number(phase_device[p]);
            tx_idle_max = p[0] ? 0 : 16;
            rx_idle_max = p[1] ? 0 : 16;
            phase_target = requests_sent + RANDOM_REQUESTS / 4;
            while (requests_sent < phase_target) begin
                if ($urandom_range(0, 99) < 85) run_id_lifecycle();
                else send_random_noise();
            end
        end
    endtask

    initial begin
        reset_allocator_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_config_after_reset();
        test_directed_requests();
        test_count_ramp();
        test_stack_empty_and_full();
        test_output_stall();
        test_random_traffic();
        wait_drained();
        $display("Sent %0d requests and checked %0d results with %0d mismatches.",
                 requests_sent, results_checked, mismatches);
        $display("Covered all actions, device numbers 0 to 3, back-to-back count ramps, %s",
                 "stack empty and full, and a long output stall.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
